// ===== hdl/iafp_pkg.sv =====
package iafp_pkg;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 4;
    localparam int RAW_W    = 16;
    localparam int OP_W     = 18;
    localparam int PROD_W   = 40;
    localparam int RES_W    = 26;
    localparam int COUNT_W  = 32;
    localparam int FRAC_W   = 11;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [POS_W-1:0]  POS_HEADER   = 4'd0;
    localparam logic [POS_W-1:0]  POS_TYPE     = 4'd1;
    localparam logic [POS_W-1:0]  POS_PAY_LO   = 4'd2;
    localparam logic [POS_W-1:0]  POS_PAY_HI   = 4'd7;
    localparam logic [POS_W-1:0]  POS_CHECKSUM = 4'd10;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] ANGLE_TYPE  = 8'h53;

    localparam logic signed [OP_W-1:0]   QUARTER_TURN_RAW = 18'sd16384;
    localparam logic signed [OP_W-1:0]   HALF_TURN_RAW    = 18'sd32768;
    localparam logic signed [PROD_W-1:0] SCALE_NUM        = 40'sd1125000;
    localparam logic signed [PROD_W-1:0] TRUNC_BIAS       = 40'sd2047;

    typedef struct packed {
        logic signed [RAW_W-1:0] r0;
        logic signed [RAW_W-1:0] r1;
        logic signed [RAW_W-1:0] r2;
    } angle_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== hdl/iafp_if.sv =====
interface iafp_byte_if;
    logic                         valid;
    logic                         ready;
    logic [iafp_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface iafp_angle_if;
    logic                                valid;
    logic                                ready;
    logic signed [iafp_pkg::RES_W-1:0]   roll_e5;
    logic signed [iafp_pkg::RES_W-1:0]   pitch_e5;
    logic [iafp_pkg::RES_W-1:0]          yaw_e5;
    logic [iafp_pkg::COUNT_W-1:0]        frame_count;

    modport source (output valid, output roll_e5, output pitch_e5, output yaw_e5,
                    output frame_count, input ready);
    modport sink   (input valid, input roll_e5, input pitch_e5, input yaw_e5,
                    input frame_count, output ready);
endinterface

// ===== hdl/iafp_front.sv =====
module iafp_front (
    input  logic                     clk,
    input  logic                     rst_n,
    iafp_byte_if.sink                rx,
    input  iafp_pkg::queue_status_t  q_status,
    output logic                     push,
    output iafp_pkg::angle_job_t     push_job
);
    import iafp_pkg::*;

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;
    logic [BYTE_W-1:0] type_reg;
    logic [BYTE_W-1:0] pay_reg [6];
    logic [POS_W-1:0]  pay_off;
    logic              accept;

    assign rx.ready = !q_status.full;
    assign accept   = rx.valid && rx.ready;
    assign pay_off  = pos_reg - POS_PAY_LO;

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        push     = 1'b0;
        if (accept)
        begin
            priority if (pos_reg == POS_HEADER)
            begin
                if (rx.rx_byte == HEADER_BYTE)
                begin
                    pos_next = POS_TYPE;
                    sum_next = rx.rx_byte;
                end
            end
            else if (pos_reg == POS_CHECKSUM)
            begin
                pos_next = POS_HEADER;
                push     = (rx.rx_byte == sum_reg) && (type_reg == ANGLE_TYPE);
            end
            else
            begin
                pos_next = pos_reg + 4'd1;
                sum_next = sum_reg + rx.rx_byte;
            end
        end
    end

    assign push_job.r0 = {pay_reg[1], pay_reg[0]};
    assign push_job.r1 = {pay_reg[3], pay_reg[2]};
    assign push_job.r2 = {pay_reg[5], pay_reg[4]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HEADER;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (accept && pos_reg == POS_TYPE)
        begin
            type_reg <= rx.rx_byte;
        end
        if (accept && pos_reg >= POS_PAY_LO && pos_reg <= POS_PAY_HI)
        begin
            pay_reg[pay_off[2:0]] <= rx.rx_byte;
        end
    end

endmodule

// ===== hdl/iafp_queue.sv =====
module iafp_queue #(
    parameter int DEPTH = iafp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  iafp_pkg::angle_job_t     push_job,
    input  logic                     pop,
    output iafp_pkg::angle_job_t     pop_job,
    output iafp_pkg::queue_status_t  status
);
    import iafp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    angle_job_t        mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    assign status.full  = (cnt_reg == FULL_CNT);
    assign status.empty = (cnt_reg == '0);
    assign pop_job      = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hdl/iafp_back.sv =====
module iafp_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  iafp_pkg::queue_status_t  q_status,
    input  iafp_pkg::angle_job_t     pop_job,
    output logic                     pop,
    iafp_angle_if.source             angle
);
    import iafp_pkg::*;

    logic                      op_v_reg;
    logic                      prod_v_reg;
    logic                      out_v_reg;
    logic                      op_ld;
    logic                      prod_ld;
    logic                      out_ld;

    logic signed [OP_W-1:0]    roll_op_reg;
    logic signed [OP_W-1:0]    pitch_op_reg;
    logic signed [OP_W-1:0]    yaw_op_reg;
    logic signed [OP_W-1:0]    roll_op_next;
    logic signed [OP_W-1:0]    pitch_op_next;
    logic signed [OP_W-1:0]    yaw_op_next;

    logic signed [PROD_W-1:0]  roll_prod_reg;
    logic signed [PROD_W-1:0]  pitch_prod_reg;
    logic signed [PROD_W-1:0]  yaw_prod_reg;
    logic signed [PROD_W-1:0]  roll_adj;
    logic signed [PROD_W-1:0]  pitch_adj;
    logic signed [PROD_W-1:0]  yaw_adj;

    logic signed [RES_W-1:0]   roll_reg;
    logic signed [RES_W-1:0]   pitch_reg;
    logic [RES_W-1:0]          yaw_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic [COUNT_W-1:0]        frame_count_reg;

    assign out_ld  = prod_v_reg && (!out_v_reg || angle.ready);
    assign prod_ld = op_v_reg && (!prod_v_reg || out_ld);
    assign op_ld   = !q_status.empty && (!op_v_reg || prod_ld);
    assign pop     = op_ld;

    assign roll_op_next  = OP_W'(pop_job.r1);
    assign pitch_op_next = QUARTER_TURN_RAW - OP_W'(pop_job.r0);
    assign yaw_op_next   = HALF_TURN_RAW - OP_W'(pop_job.r2);

    // Division by 2048 must truncate toward zero, so negative products get a bias.
    assign roll_adj  = roll_prod_reg  + (roll_prod_reg[PROD_W-1]  ? TRUNC_BIAS : '0);
    assign pitch_adj = pitch_prod_reg + (pitch_prod_reg[PROD_W-1] ? TRUNC_BIAS : '0);
    assign yaw_adj   = yaw_prod_reg   + (yaw_prod_reg[PROD_W-1]   ? TRUNC_BIAS : '0);

    assign count_next = count_reg + 1'b1;

    assign angle.valid       = out_v_reg;
    assign angle.roll_e5     = roll_reg;
    assign angle.pitch_e5    = pitch_reg;
    assign angle.yaw_e5      = yaw_reg;
    assign angle.frame_count = frame_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (op_ld)
            begin
                op_v_reg <= 1'b1;
            end
            else if (prod_ld)
            begin
                op_v_reg <= 1'b0;
            end
            if (prod_ld)
            begin
                prod_v_reg <= 1'b1;
            end
            else if (out_ld)
            begin
                prod_v_reg <= 1'b0;
            end
            if (out_ld)
            begin
                out_v_reg <= 1'b1;
                count_reg <= count_next;
            end
            else if (angle.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_ld)
        begin
            roll_op_reg  <= roll_op_next;
            pitch_op_reg <= pitch_op_next;
            yaw_op_reg   <= yaw_op_next;
        end
        if (prod_ld)
        begin
            roll_prod_reg  <= PROD_W'(roll_op_reg)  * SCALE_NUM;
            pitch_prod_reg <= PROD_W'(pitch_op_reg) * SCALE_NUM;
            yaw_prod_reg   <= PROD_W'(yaw_op_reg)   * SCALE_NUM;
        end
        if (out_ld)
        begin
            roll_reg        <= roll_adj[FRAC_W +: RES_W];
            pitch_reg       <= pitch_adj[FRAC_W +: RES_W];
            yaw_reg         <= yaw_adj[FRAC_W +: RES_W];
            frame_count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/imu_angle_frame_parser.sv =====
// Channel   Modport  Transaction
// rx        sink     one serial byte from the sensor
// angle     source   roll, pitch, yaw and frame count of one good angle packet
//
// One byte is taken every cycle; the checksum byte of a good angle packet yields
// a result through the job queue, operand, multiply and output registers.
// Reset clears the byte position, the queue and the frame count.
// rx stalls only while the job queue is full; the queue lets the byte framer run
// while angle is held back.
module imu_angle_frame_parser #(
    parameter int QUEUE_DEPTH = iafp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    iafp_byte_if.sink     rx,
    iafp_angle_if.source  angle
);
    import iafp_pkg::*;

    queue_status_t  q_status;
    logic           push;
    logic           pop;
    angle_job_t     push_job;
    angle_job_t     pop_job;

    iafp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    iafp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    iafp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_job  (pop_job),
        .pop      (pop),
        .angle    (angle)
    );

endmodule
